// File: rtl/hofr_pkg.sv
// Shared constants and types for the heading offset low-pass filter.
package hofr_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int TIMER_BITS     = 24;
  localparam int GAIN_FRAC_BITS = 16;

  localparam int GAIN_W   = GAIN_FRAC_BITS + 1;   // wide enough to hold a gain of exactly one
  // signed multiplier operand: holds a zero-extended gain or a signed angle
  localparam int MUL_W    = (GAIN_W + 1 > ANGLE_BITS) ? GAIN_W + 1 : ANGLE_BITS;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int DCNT_W   = $clog2(GAIN_W + 1);
  localparam int COUNT_W  = 16;
  localparam int DECAY_W  = 16;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW_A = (TIMER_BITS > GAIN_W) ? TIMER_BITS : GAIN_W;
  localparam int CFG_DW   = (CFG_DW_A > COUNT_W) ? CFG_DW_A : COUNT_W;
  localparam int TDATA_W  = ((ANGLE_BITS + 7) / 8) * 8;

  localparam logic [GAIN_W-1:0]     GAIN_ONE    = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [TIMER_BITS-1:0] SAMPLE_TICK = TIMER_BITS'(256);
  localparam logic [COUNT_W-1:0]    COUNT_MAX   = '1;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_REJ_EN    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_BASE_GAIN = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MAX_REJ   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DECAY     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_REJ_SCALE = 3'd4;
  localparam logic [CFG_AW-1:0] REG_INIT_LIM  = 3'd5;

  typedef logic [ANGLE_BITS-1:0] angle_t;
  typedef logic [GAIN_W-1:0]     gain_t;
  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [COUNT_W-1:0]    count_t;

  // request to the divider
  typedef struct packed {
    logic  start;
    gain_t divisor;
  } div_req_t;

  // answer from the divider
  typedef struct packed {
    logic  done;
    gain_t quotient;
  } div_rsp_t;

  function automatic gain_t gain_sat(input gain_t g);
    return (g > GAIN_ONE) ? GAIN_ONE : g;
  endfunction

endpackage

// File: rtl/hofr_div.sv
// Bit-serial restoring divider: GAIN_ONE / divisor, one quotient bit per cycle.
module hofr_div
  import hofr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [GAIN_W:0]   rem;
  gain_t             quot;
  gain_t             divisor;
  logic [DCNT_W-1:0] count;
  logic              busy;
  logic              done;

  logic [GAIN_W:0]   trial;
  logic              fits;

  assign trial = {rem[GAIN_W-1:0], quot[GAIN_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= DCNT_W'(GAIN_W);
      end else if (busy) begin
        count <= count - DCNT_W'(1);
        if (count == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient shifts in from the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quot    <= GAIN_ONE;
      divisor <= req.divisor;
    end else if (busy) begin
      rem  <= fits ? (trial - {1'b0, divisor}) : trial;
      quot <= {quot[GAIN_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

// File: rtl/heading_offset_filter_rejection.sv
// Top level: heading offset low-pass filter with disturbance rejection.
// Each word runs S_IDLE, S_PREP, then S_MULK and S_KUPD when a timed-out
// disturbance scales the gain, S_DIV_GO and S_DIV_WAIT for the 1/n divider in the
// start phase, then S_MULS and S_OUT. A new word is taken once the previous
// result has gone into the output register, even if it is not yet taken.
// Reset (rst, synchronous): registers to defaults, estimate 0, timer 0, start phase on.
module heading_offset_filter_rejection
  import hofr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,  // [15:0] heading_sample
  input  logic [1:0]         s_axis_tuser,  // [0] disturbed, [1] start_req
  // output stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,  // [15:0] heading_filtered
  // configuration
  input  logic               cfg_we,
  input  logic [CFG_AW-1:0]  cfg_addr,
  input  logic [CFG_DW-1:0]  cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MULK,
    S_KUPD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MULS,
    S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic           rej_en;
  gain_t          base_gain;
  timer_t         max_rej;
  logic [DECAY_W-1:0] decay;
  gain_t          rej_scale;
  count_t         init_limit;

  // filter state
  angle_t estimate;
  timer_t timer;
  count_t init_count;
  logic   init_active;

  // per-word working registers
  angle_t sample;
  logic   disturbed;
  logic   start_req;
  angle_t dif;
  gain_t  k;
  gain_t  divisor;
  logic   do_div;
  logic signed [PROD_W-1:0] prod;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // ---- configuration write port ----
  always_ff @(posedge clk) begin
    if (rst) begin
      rej_en     <= 1'b1;
      base_gain  <= GAIN_W'(66);
      max_rej    <= TIMER_BITS'(1536000);
      decay      <= DECAY_W'(512);
      rej_scale  <= GAIN_W'(32768);
      init_limit <= COUNT_W'(1000);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_REJ_EN:    rej_en     <= cfg_wdata[0];
        REG_BASE_GAIN: base_gain  <= cfg_wdata[GAIN_W-1:0];
        REG_MAX_REJ:   max_rej    <= cfg_wdata[TIMER_BITS-1:0];
        REG_DECAY:     decay      <= cfg_wdata[DECAY_W-1:0];
        REG_REJ_SCALE: rej_scale  <= cfg_wdata[GAIN_W-1:0];
        REG_INIT_LIM:  init_limit <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- setup arithmetic: start flag applied first ----
  angle_t est_eff;
  timer_t timer_eff;
  count_t cnt_eff;
  logic   active_eff;
  logic   hold;        // disturbed, rejection on, timer still within limit
  logic   scale_k;     // disturbed after timeout: gain is scaled down
  logic [TIMER_BITS:0] timer_inc;
  timer_t timer_new;
  count_t cnt_new;

  always_comb begin
    est_eff    = start_req ? sample : estimate;
    timer_eff  = start_req ? '0     : timer;
    cnt_eff    = start_req ? '0     : init_count;
    active_eff = start_req | init_active;

    hold    = rej_en & disturbed & (timer_eff <= max_rej);
    scale_k = rej_en & disturbed & (timer_eff > max_rej);

    timer_inc = {1'b0, timer_eff} + {1'b0, SAMPLE_TICK};
    if (hold) begin
      timer_new = timer_inc[TIMER_BITS] ? '1 : timer_inc[TIMER_BITS-1:0];
    end else if (rej_en && !disturbed) begin
      timer_new = (timer_eff > TIMER_BITS'(decay)) ? timer_eff - TIMER_BITS'(decay) : '0;
    end else begin
      timer_new = timer_eff;
    end

    cnt_new = (cnt_eff == COUNT_MAX) ? cnt_eff : cnt_eff + COUNT_W'(1);
  end

  // ---- shared multiplier: k times scale, then k times difference ----
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;

  assign mul_a = MUL_W'(signed'({1'b0, k}));
  assign mul_b = (state == S_MULK) ? MUL_W'(signed'({1'b0, gain_sat(rej_scale)}))
                                   : MUL_W'(signed'(dif));

  // ---- rounding: floor((p + half) / 2^GAIN_FRAC_BITS), low angle bits ----
  logic signed [PROD_W-1:0] rnd;
  angle_t est_new;

  assign rnd     = prod + PROD_W'(GAIN_ONE >> 1);
  assign est_new = estimate + rnd[ANGLE_BITS+GAIN_FRAC_BITS-1:GAIN_FRAC_BITS];

  assign div_req.start   = (state == S_DIV_GO);
  assign div_req.divisor = divisor;

  hofr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      estimate      <= '0;
      timer         <= '0;
      init_count    <= '0;
      init_active   <= 1'b1;
      m_axis_tvalid <= 1'b0;
    end else begin
      // output register: refilled from S_OUT, emptied when taken
      if ((state == S_OUT) && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          estimate <= est_eff;
          timer    <= timer_new;
          if (active_eff) begin
            init_count  <= cnt_new;
            init_active <= (init_limit > cnt_new);
          end else begin
            init_count  <= cnt_eff;
            init_active <= 1'b0;
          end
          if (scale_k) begin
            state <= S_MULK;
          end else if (active_eff) begin
            state <= S_DIV_GO;
          end else begin
            state <= S_MULS;
          end
        end
        S_MULK:   state <= S_KUPD;
        S_KUPD:   state <= do_div ? S_DIV_GO : S_MULS;
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            state <= S_MULS;
          end
        end
        S_MULS:   state <= S_OUT;
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            estimate      <= est_new;
            state         <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        sample    <= s_axis_tdata[ANGLE_BITS-1:0];
        disturbed <= s_axis_tuser[0];
        start_req <= s_axis_tuser[1];
      end
      S_PREP: begin
        dif     <= sample - est_eff;
        k       <= hold ? '0 : gain_sat(base_gain);
        divisor <= GAIN_W'(cnt_eff) + GAIN_W'(1);
        do_div  <= active_eff;
      end
      S_MULK: prod <= mul_a * mul_b;
      S_KUPD: k    <= prod[GAIN_FRAC_BITS+GAIN_W-1:GAIN_FRAC_BITS];
      S_DIV_WAIT: begin
        if (div_rsp.done && (k < div_rsp.quotient)) begin
          k <= div_rsp.quotient;
        end
      end
      S_MULS: prod <= mul_a * mul_b;
      S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= TDATA_W'(est_new);
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);

endmodule

// File: sim/heading_offset_filter_rejection_test.sv
// Self-checking testbench for the heading offset low-pass filter with disturbance rejection.
`timescale 1ns / 100ps

module heading_offset_filter_rejection_test;
  import hofr_pkg::*;

  // ---------------------------------------------------------------------------
  // Run constants
  // ---------------------------------------------------------------------------
  localparam int          RAND_PHASES   = 14;
  localparam int          PHASE_WORDS   = 150;
  localparam int          PRESS_WORDS   = 40;
  localparam int          HOLD_CYCLES   = 2000;     // long receiver hold-off
  localparam int          SETTLE_CYCLES = 40;
  localparam longint      CYCLE_LIMIT   = 500000;
  localparam int unsigned TIMER_TOP     = (1 << TIMER_BITS) - 1;
  localparam int          DIR_ROWS      = 31;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // one row of the directed table: either a word to send or a register write
  typedef struct {
    row_kind_t         kind;
    angle_t            sample;
    logic              dflag;
    logic              strt;
    logic              checked;   // want is typed in; otherwise predicted
    angle_t            want;
    logic [CFG_AW-1:0] idx;
    int unsigned       val;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;   // [15:0] heading_sample
  logic [1:0]         s_axis_tuser = '0;   // [0] disturbed, [1] start_req
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;        // [15:0] heading_filtered
  logic               cfg_we = 1'b0;
  logic [CFG_AW-1:0]  cfg_addr = '0;
  logic [CFG_DW-1:0]  cfg_wdata = '0;

  heading_offset_filter_rejection u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the registers and the filter state
  // ---------------------------------------------------------------------------
  logic        rej_en_q   = 1'b1;
  gain_t       gain_q     = gain_t'(66);
  int unsigned max_rej_q  = 1536000;
  int unsigned decay_q    = 512;
  gain_t       scale_q    = gain_t'(32768);
  int          init_lim_q = 1000;

  angle_t      est_q      = '0;
  int unsigned timer_q    = 0;     // samples, 8 fraction bits
  int          count_q    = 0;     // samples seen in the start phase
  logic        init_on_q  = 1'b1;

  angle_t      heading_due [$];    // filtered headings still to arrive
  int          error_count = 0;
  longint      cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_requests = 0;  // bumped by the stimulus, served by the receiver

  // Directed table. Typed-in results are the obvious ones: gain of one makes
  // the estimate follow the sample, gain of zero holds it, half gain moves it halfway.
  dir_row_t dir_rows [DIR_ROWS] = '{
    // fresh state after reset, no start flag: first word passes through
    '{ROW_WORD, 16'h1234, 1'b0, 1'b0, 1'b1, 16'h1234, REG_REJ_EN, 0},
    '{ROW_WORD, 16'h7FFF, 1'b0, 1'b1, 1'b1, 16'h7FFF, REG_REJ_EN, 0},
    '{ROW_WORD, 16'h8000, 1'b0, 1'b0, 1'b0, 16'h0000, REG_REJ_EN, 0},
    // exactly pi apart: difference wraps to -pi, half gain lands on -pi/2
    '{ROW_WORD, 16'h0000, 1'b0, 1'b1, 1'b1, 16'h0000, REG_REJ_EN, 0},
    '{ROW_WORD, 16'h8000, 1'b0, 1'b0, 1'b1, 16'hC000, REG_REJ_EN, 0},
    '{ROW_WORD, 16'h4000, 1'b1, 1'b0, 1'b0, 16'h0000, REG_REJ_EN, 0},
    '{ROW_WORD, 16'hFFFF, 1'b1, 1'b0, 1'b0, 16'h0000, REG_REJ_EN, 0},
    '{ROW_WORD, 16'h0001, 1'b0, 1'b0, 1'b0, 16'h0000, REG_REJ_EN, 0},
    // gain register above one clamps to one; start phase ends at once
    '{ROW_CFG,  16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, REG_BASE_GAIN, 17'h1FFFF},
    '{ROW_CFG,  16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, REG_INIT_LIM, 0},
    '{ROW_WORD, 16'h0100, 1'b0, 1'b1, 1'b1, 16'h0100, REG_REJ_EN, 0},
    '{ROW_WORD, 16'h7F00, 1'b0, 1'b0, 1'b1, 16'h7F00, REG_REJ_EN, 0},
    '{ROW_WORD, 16'h8000, 1'b0, 1'b0, 1'b1, 16'h8000, REG_REJ_EN, 0},
    // rejection off: disturbance flag ignored, timer untouched
    '{ROW_CFG,  16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, REG_REJ_EN, 0},
    '{ROW_WORD, 16'h1357, 1'b1, 1'b0, 1'b1, 16'h1357, REG_REJ_EN, 0},
    // zero time limit: one held sample, then scaled gain
    '{ROW_CFG,  16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, REG_REJ_EN, 1},
    '{ROW_CFG,  16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, REG_MAX_REJ, 0},
    '{ROW_WORD, 16'h2000, 1'b1, 1'b0, 1'b1, 16'h1357, REG_REJ_EN, 0},
    '{ROW_WORD, 16'h2000, 1'b1, 1'b0, 1'b0, 16'h0000, REG_REJ_EN, 0},
    '{ROW_CFG,  16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, REG_REJ_SCALE, 17'h1FFFF},
    '{ROW_WORD, 16'h5555, 1'b1, 1'b0, 1'b1, 16'h5555, REG_REJ_EN, 0},
    // full decay drains the timer in one clean sample
    '{ROW_CFG,  16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, REG_DECAY, 16'hFFFF},
    '{ROW_WORD, 16'h6000, 1'b0, 1'b0, 1'b1, 16'h6000, REG_REJ_EN, 0},
    '{ROW_WORD, 16'h7000, 1'b1, 1'b0, 1'b1, 16'h6000, REG_REJ_EN, 0},
    // zero gains hold the estimate
    '{ROW_CFG,  16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, REG_BASE_GAIN, 0},
    '{ROW_CFG,  16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, REG_REJ_SCALE, 0},
    '{ROW_WORD, 16'h0000, 1'b0, 1'b0, 1'b1, 16'h6000, REG_REJ_EN, 0},
    // longest start phase, small steps near +-pi
    '{ROW_CFG,  16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, REG_INIT_LIM, 16'hFFFF},
    '{ROW_WORD, 16'h8001, 1'b0, 1'b1, 1'b1, 16'h8001, REG_REJ_EN, 0},
    '{ROW_WORD, 16'h7FFF, 1'b0, 1'b0, 1'b0, 16'h0000, REG_REJ_EN, 0},
    '{ROW_WORD, 16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000, REG_REJ_EN, 0}
  };

  // ---------------------------------------------------------------------------
  // Filter predictor: one step per accepted word
  // ---------------------------------------------------------------------------
  function automatic angle_t predict_heading(input angle_t smp, input logic dflag,
                                             input logic strt);
    logic signed [ANGLE_BITS-1:0] d16;
    longint dif, k, scl, fl, step;
    if (strt) begin
      est_q     = smp;
      timer_q   = 0;
      count_q   = 0;
      init_on_q = 1'b1;
    end
    d16 = smp - est_q;                        // wrapped; pi apart becomes -pi
    dif = longint'(d16);
    k   = longint'((gain_q > GAIN_ONE) ? GAIN_ONE : gain_q);
    scl = longint'((scale_q > GAIN_ONE) ? GAIN_ONE : scale_q);
    if (rej_en_q) begin
      if (dflag) begin
        if (timer_q <= max_rej_q) begin
          // still inside the rejection window: hold, timer saturates
          timer_q = (timer_q + 256 > TIMER_TOP) ? TIMER_TOP : timer_q + 256;
          k = 0;
        end else begin
          k = (k * scl) >> GAIN_FRAC_BITS;
        end
      end else begin
        timer_q = (timer_q > decay_q) ? timer_q - decay_q : 0;
      end
    end
    if (init_on_q) begin
      fl = longint'(65536 / (count_q + 1));
      if (k < fl) k = fl;
      if (count_q < 65535) count_q++;
      if (init_lim_q < count_q + 1) init_on_q = 1'b0;
    end
    // round to nearest, ties toward +inf; arithmetic shift floors negatives
    step  = (k * dif + 32768) >>> GAIN_FRAC_BITS;
    est_q = est_q + angle_t'(step);
    return est_q;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // register write: raise we, lower it after the write edge, then idle (keeps we edges apart)
  task automatic write_reg(input logic [CFG_AW-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[CFG_DW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_REJ_EN:    rej_en_q   = val[0];
      REG_BASE_GAIN: gain_q     = val[GAIN_W-1:0];
      REG_MAX_REJ:   max_rej_q  = val & TIMER_TOP;
      REG_DECAY:     decay_q    = val & 32'hFFFF;
      REG_REJ_SCALE: scale_q    = val[GAIN_W-1:0];
      REG_INIT_LIM:  init_lim_q = int'(val & 32'hFFFF);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one word and wait for its handshake. tvalid stays high across
  // back-to-back words; it drops only for a chosen idle gap or in drain().
  task automatic send_word(input angle_t smp, input logic dflag, input logic strt,
                           input logic checked, input angle_t want);
    angle_t pred;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'(smp);
    s_axis_tuser  <= {strt, dflag};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pred = predict_heading(smp, dflag, strt);
    heading_due.push_back(checked ? want : pred);
    if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
  endtask

  // stop offering, let every expected word come back, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (heading_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 82; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 82; end
      default:   begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  // sel: 0 low extreme, 1 high extreme, 2 reset value, 3 random
  function automatic int unsigned pick_val(input int sel, input int unsigned lo,
                                           input int unsigned hi, input int unsigned dflt,
                                           input int unsigned rnd);
    case (sel)
      0:       return lo;
      1:       return hi;
      2:       return dflt;
      default: return rnd;
    endcase
  endfunction

  // every register per phase; first phase all high, second all low
  task automatic pick_config(input int p);
    int sel [6];
    for (int r = 0; r < 6; r++)
      sel[r] = (p == 0) ? 1 : (p == 1) ? 0 : $urandom_range(3, 0);
    write_reg(REG_REJ_EN, pick_val(sel[0], 0, 1, 1, $urandom_range(1, 0)));
    write_reg(REG_BASE_GAIN, pick_val(sel[1], 0, $urandom_range(1, 0) ? 65536 : 17'h1FFFF, 66,
              $urandom_range(1, 0) ? $urandom_range(4096, 0) : $urandom_range(65536, 0)));
    // small limits so disturbed runs time out inside a phase
    write_reg(REG_MAX_REJ, pick_val(sel[2], 0, 24'hFFFFFF, 1536000,
              ($urandom_range(3, 0) == 0) ? $urandom_range(24'hFFFFFF, 0)
                                          : 256 * $urandom_range(40, 0) + $urandom_range(255, 0)));
    write_reg(REG_DECAY, pick_val(sel[3], 0, 16'hFFFF, 512,
              $urandom_range(1, 0) ? $urandom_range(2048, 0) : $urandom_range(65535, 0)));
    write_reg(REG_REJ_SCALE, pick_val(sel[4], 0, $urandom_range(1, 0) ? 65536 : 17'h1FFFF,
              32768, $urandom_range(65536, 0)));
    write_reg(REG_INIT_LIM, pick_val(sel[5], 0, 16'hFFFF, 1000,
              $urandom_range(1, 0) ? $urandom_range(64, 0) : $urandom_range(65535, 0)));
  endtask

  // Mostly well-formed tracks: often a start word, then samples jittering around a
  // slowly drifting heading, disturbance in runs. A few jumps near pi and
  // fully random words mixed in.
  task automatic random_words(input int count);
    angle_t base, smp;
    logic   dflag, strt;
    int     r;
    base  = angle_t'($urandom);
    dflag = 1'b0;
    for (int i = 0; i < count; i++) begin
      strt = (i == 0) ? logic'($urandom_range(1, 0)) : ($urandom_range(99, 0) < 3);
      if (strt) base = angle_t'($urandom);
      if ($urandom_range(99, 0) < 12) dflag = ~dflag;
      r = $urandom_range(99, 0);
      if (r < 75)
        smp = base + angle_t'($urandom_range(600, 0)) - angle_t'(300);
      else if (r < 85)
        smp = base + 16'h8000 + angle_t'($urandom_range(4, 0)) - angle_t'(2);
      else begin
        smp   = angle_t'($urandom);
        dflag = logic'($urandom_range(1, 0));
      end
      base = base + angle_t'($urandom_range(8, 0)) - angle_t'(4);
      send_word(smp, dflag, strt, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: checks each accepted word, drives tready, serves hold-offs
  // ---------------------------------------------------------------------------
  initial begin
    angle_t want;
    int     hold_left;
    int     hold_served;
    hold_left   = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        if (heading_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
          error_count++;
        end else begin
          want = heading_due.pop_front();
          if (m_axis_tdata[ANGLE_BITS-1:0] !== want) begin
            $display("%0t: heading_filtered mismatch, expected %h, actual %h",
                     $time, want, m_axis_tdata);
            error_count++;
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("heading_offset_filter_rejection_test: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, block left at its reset settings for the first rows
    set_idling(IDLE_BOTH);
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_word(dir_rows[i].sample, dir_rows[i].dflag, dir_rows[i].strt,
                  dir_rows[i].checked, dir_rows[i].want);
      end
    end
    drain();

    // random phases; state carries over between phases unless a start word comes
    for (int p = 0; p < RAND_PHASES; p++) begin
      pick_config(p);
      set_idling(idle_mode_t'(p % 4));
      random_words(PHASE_WORDS);
      drain();
    end

    // receiver holds off for a long stretch while the sender keeps offering
    set_idling(IDLE_NONE);
    hold_requests++;
    random_words(PRESS_WORDS);
    drain();

    if (error_count == 0) begin
      $display("heading_offset_filter_rejection_test: clean");
    end else begin
      $display("heading_offset_filter_rejection_test: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/hofr_pkg.sv
rtl/hofr_div.sv
rtl/heading_offset_filter_rejection.sv
sim/heading_offset_filter_rejection_test.sv
